// ===== hw/rtl/tndb_pkg.sv =====
// Shared types and constants for the two-nearest direction blend.
// Used by every module of the block but tndb_ram; depends on nothing.
package tndb_pkg;

	localparam int FIELD_W  = 24;
	localparam int IDX_W    = 6;
	localparam int CFG_W    = 7;
	localparam int USED_W   = 2;
	localparam int S_DATA_W = 152;
	localparam int M_DATA_W = 80;

	localparam int OFF_IDX   = 0;
	localparam int OFF_POS_X = 6;
	localparam int OFF_POS_Y = 30;
	localparam int OFF_POS_Z = 54;
	localparam int OFF_VEC_X = 78;
	localparam int OFF_VEC_Y = 102;
	localparam int OFF_VEC_Z = 126;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [USED_W-1:0] USED_NONE = 2'd0;
	localparam logic [USED_W-1:0] USED_ONE  = 2'd1;
	localparam logic [USED_W-1:0] USED_TWO  = 2'd2;

	typedef struct packed {
		logic start;
		logic is_div;
	} iter_req_t;

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b00000000001,
		ST_SCAN_RD   = 11'b00000000010,
		ST_SCAN_MUL  = 11'b00000000100,
		ST_PICK_RD   = 11'b00000001000,
		ST_PICK_LD   = 11'b00000010000,
		ST_ROOT_GO   = 11'b00000100000,
		ST_ROOT_WAIT = 11'b00001000000,
		ST_BLEND     = 11'b00010000000,
		ST_DIV_GO    = 11'b00100000000,
		ST_DIV_WAIT  = 11'b01000000000,
		ST_FIN       = 11'b10000000000
	} state_t;

endpackage

// ===== hw/rtl/tndb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tndb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/tndb_iter.sv =====
// Shared iterative unit: floor square root or unsigned floor division,
// one subtract-and-compare step per cycle. Depends on tndb_pkg.
module tndb_iter #(
	parameter int CB = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tndb_pkg::iter_req_t req,
	input  logic [2*CB+2:0]    a,
	input  logic [CB+1:0]      den,
	output logic               done,
	output logic [CB:0]        result
);

	localparam int UW = 2 * CB + 3;
	localparam int CW = $clog2(CB + 1);

	logic          busy_q;
	logic          div_q;
	logic [CW-1:0] cnt_q;
	logic [UW-1:0] rem_q;
	logic [UW-1:0] res_q;
	logic [UW-1:0] bsh_q;
	logic [UW-1:0] sub_b;
	logic [UW:0]   diff;
	logic          ge;

	assign sub_b  = div_q ? bsh_q : (res_q + bsh_q);
	assign diff   = {1'b0, rem_q} - {1'b0, sub_b};
	assign ge     = ~diff[UW];
	assign result = res_q[CB:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(CB);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			rem_q <= a;
			res_q <= '0;
			bsh_q <= req.is_div ? (UW'(den) << CB) : (UW'(1) << (2 * CB));
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[UW-1:0];
			end
			if (div_q) begin
				res_q <= {res_q[UW-2:0], ge};
				bsh_q <= bsh_q >> 1;
			end else begin
				res_q <= ge ? ((res_q >> 1) | bsh_q) : (res_q >> 1);
				bsh_q <= bsh_q >> 2;
			end
		end
	end

endmodule

// ===== hw/rtl/two_nearest_direction_blend.sv =====
// Load: written to the guide table, ready again at once. Query: scans the first n entries
// with the shared multiplier, then takes square roots of the two nearest distances (not for
// one entry) and divides each blended axis in the iterative unit; no entries skip to the result.
// One item at a time; a finished result may wait while the next item is taken.
// arst_n clears control and the register; guide table contents stay undefined.
// Depends on tndb_pkg, tndb_ram and tndb_iter.
module two_nearest_direction_blend #(
	parameter int MAX_GUIDES = 64,
	parameter int COORD_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tndb_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// entry_index, pos_x, pos_y, pos_z, vec_x, vec_y, vec_z, then zero pad.
	input  logic [tndb_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// action.
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// dir_x, dir_y, dir_z, guides_used, then zero pad.
	output logic [tndb_pkg::M_DATA_W-1:0]  m_axis_tdata
);

	localparam int CB   = COORD_BITS;
	localparam int AW   = $clog2(MAX_GUIDES);
	localparam int KW   = $clog2(MAX_GUIDES + 1);
	localparam int MW   = CB + 2;
	localparam int DW   = 2 * CB + 2;
	localparam int RW   = CB + 1;
	localparam int NW   = 2 * CB + 3;
	localparam int RAMW = 6 * CB + 3;
	localparam logic signed [MW-1:0] SAT_HI = {3'b000, {(CB-1){1'b1}}};
	localparam logic signed [MW-1:0] SAT_LO = {3'b111, {(CB-1){1'b0}}};

	tndb_pkg::state_t state_q;

	logic [tndb_pkg::CFG_W-1:0] cnt_cfg_q;
	logic                       m_valid_q;
	logic [tndb_pkg::M_DATA_W-1:0] m_data_q;

	logic signed [CB-1:0] in_px, in_py, in_pz, in_vx, in_vy, in_vz;
	logic signed [CB:0]   in_dx, in_dy, in_dz;
	logic [tndb_pkg::IDX_W-1:0] in_idx;
	logic                 acc_in;
	logic                 ram_we;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [RAMW-1:0]      ram_rdata;

	logic signed [CB-1:0] qx_q, qy_q, qz_q;
	logic signed [CB-1:0] res_q [3];
	logic [KW-1:0]        n_q, k_q, n_lim;
	logic [1:0]           step_q, axis_q;
	logic                 sel_q;
	logic [1:0]           found_q;
	logic [DW-1:0]        acc_q, d1_q, d2_q, sval;
	logic [AW-1:0]        i1_q, i2_q;
	logic signed [CB:0]   dir1_q [3];
	logic signed [CB:0]   dir2_q [3];
	logic [RW-1:0]        r1_q, r2_q;
	logic signed [NW-1:0] num_q;
	logic                 neg_q;

	logic signed [CB-1:0] rd_s [3];
	logic signed [CB:0]   rd_d [3];
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [2*MW-1:0] prod_q;

	tndb_pkg::iter_req_t  it_req;
	logic [NW-1:0]        it_a;
	logic [NW-1:0]        num_mag;
	logic [CB+1:0]        den;
	logic                 it_done;
	logic [RW-1:0]        it_res;
	logic signed [MW-1:0] q_signed;
	logic signed [CB-1:0] q_sat;

	assign in_idx = s_axis_tdata[tndb_pkg::OFF_IDX +: tndb_pkg::IDX_W];
	assign in_px  = $signed(s_axis_tdata[tndb_pkg::OFF_POS_X +: CB]);
	assign in_py  = $signed(s_axis_tdata[tndb_pkg::OFF_POS_Y +: CB]);
	assign in_pz  = $signed(s_axis_tdata[tndb_pkg::OFF_POS_Z +: CB]);
	assign in_vx  = $signed(s_axis_tdata[tndb_pkg::OFF_VEC_X +: CB]);
	assign in_vy  = $signed(s_axis_tdata[tndb_pkg::OFF_VEC_Y +: CB]);
	assign in_vz  = $signed(s_axis_tdata[tndb_pkg::OFF_VEC_Z +: CB]);
	assign in_dx  = (CB+1)'(in_vx) - (CB+1)'(in_px);
	assign in_dy  = (CB+1)'(in_vy) - (CB+1)'(in_py);
	assign in_dz  = (CB+1)'(in_vz) - (CB+1)'(in_pz);

	assign s_axis_tready = (state_q == tndb_pkg::ST_IDLE);
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign ram_we        = acc_in && (s_axis_tuser == tndb_pkg::ACT_LOAD)
		&& (32'(in_idx) < MAX_GUIDES);
	assign n_lim         = (32'(cnt_cfg_q) < MAX_GUIDES) ? KW'(cnt_cfg_q) : KW'(MAX_GUIDES);

	assign ram_re    = (state_q == tndb_pkg::ST_SCAN_RD) || (state_q == tndb_pkg::ST_PICK_RD);
	assign ram_raddr = (state_q == tndb_pkg::ST_SCAN_RD) ? k_q[AW-1:0] : (sel_q ? i2_q : i1_q);

	tndb_ram #(
		.WIDTH(RAMW),
		.DEPTH(MAX_GUIDES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(in_idx)),
		.wdata({in_dz, in_dy, in_dx, in_pz, in_py, in_px}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_s[0] = $signed(ram_rdata[0 +: CB]);
	assign rd_s[1] = $signed(ram_rdata[CB +: CB]);
	assign rd_s[2] = $signed(ram_rdata[2*CB +: CB]);
	assign rd_d[0] = $signed(ram_rdata[3*CB +: CB+1]);
	assign rd_d[1] = $signed(ram_rdata[4*CB+1 +: CB+1]);
	assign rd_d[2] = $signed(ram_rdata[5*CB+2 +: CB+1]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			tndb_pkg::ST_SCAN_MUL: begin
				case (step_q)
					2'd0: mul_a = MW'(rd_s[0]) - MW'(qx_q);
					2'd1: mul_a = MW'(rd_s[1]) - MW'(qy_q);
					2'd2: mul_a = MW'(rd_s[2]) - MW'(qz_q);
					default: mul_a = '0;
				endcase
				mul_b = mul_a;
			end
			tndb_pkg::ST_BLEND: begin
				if (step_q == 2'd0) begin
					mul_a = MW'(dir1_q[axis_q]);
					mul_b = $signed(MW'(r2_q));
				end else begin
					mul_a = MW'(dir2_q[axis_q]);
					mul_b = $signed(MW'(r1_q));
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign sval    = acc_q + prod_q[DW-1:0];
	assign den     = (CB+2)'(r1_q) + (CB+2)'(r2_q);
	assign num_mag = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);

	always_comb begin
		it_req.start  = 1'b0;
		it_req.is_div = 1'b0;
		it_a          = '0;
		case (state_q)
			tndb_pkg::ST_ROOT_GO: begin
				it_req.start = 1'b1;
				it_a         = NW'(sel_q ? d2_q : d1_q);
			end
			tndb_pkg::ST_DIV_GO: begin
				it_req.start  = 1'b1;
				it_req.is_div = 1'b1;
				it_a          = num_mag + NW'(den >> 1);
			end
			default: begin
				it_req.start = 1'b0;
			end
		endcase
	end

	tndb_iter #(
		.CB(CB)
	) u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (it_req),
		.a     (it_a),
		.den   (den),
		.done  (it_done),
		.result(it_res)
	);

	assign q_signed = neg_q ? -$signed({1'b0, it_res}) : $signed({1'b0, it_res});
	assign q_sat    = (q_signed > SAT_HI) ? SAT_HI[CB-1:0]
		: ((q_signed < SAT_LO) ? SAT_LO[CB-1:0] : q_signed[CB-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tndb_pkg::ST_IDLE;
			cnt_cfg_q <= '0;
			m_valid_q <= 1'b0;
			step_q    <= '0;
			axis_q    <= '0;
			sel_q     <= 1'b0;
			found_q   <= '0;
			k_q       <= '0;
			n_q       <= '0;
		end else begin
			if (cfg_we) begin
				cnt_cfg_q <= cfg_wdata;
			end
			if (state_q == tndb_pkg::ST_FIN && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				tndb_pkg::ST_IDLE: begin
					if (acc_in && (s_axis_tuser == tndb_pkg::ACT_QUERY)) begin
						found_q <= tndb_pkg::USED_NONE;
						k_q     <= '0;
						n_q     <= n_lim;
						sel_q   <= 1'b0;
						state_q <= (n_lim == '0) ? tndb_pkg::ST_FIN : tndb_pkg::ST_SCAN_RD;
					end
				end
				tndb_pkg::ST_SCAN_RD: begin
					step_q  <= '0;
					state_q <= tndb_pkg::ST_SCAN_MUL;
				end
				tndb_pkg::ST_SCAN_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						if (found_q == tndb_pkg::USED_NONE || sval < d1_q) begin
							if (found_q != tndb_pkg::USED_TWO) begin
								found_q <= found_q + 1'b1;
							end
						end else if (found_q == tndb_pkg::USED_ONE || sval < d2_q) begin
							found_q <= tndb_pkg::USED_TWO;
						end
						k_q <= k_q + 1'b1;
						state_q <= (k_q + 1'b1 == n_q) ? tndb_pkg::ST_PICK_RD
							: tndb_pkg::ST_SCAN_RD;
					end
				end
				tndb_pkg::ST_PICK_RD: begin
					state_q <= tndb_pkg::ST_PICK_LD;
				end
				tndb_pkg::ST_PICK_LD: begin
					if (found_q == tndb_pkg::USED_ONE) begin
						step_q  <= '0;
						axis_q  <= '0;
						state_q <= tndb_pkg::ST_BLEND;
					end else if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= tndb_pkg::ST_PICK_RD;
					end else begin
						sel_q   <= 1'b0;
						state_q <= tndb_pkg::ST_ROOT_GO;
					end
				end
				tndb_pkg::ST_ROOT_GO: begin
					state_q <= tndb_pkg::ST_ROOT_WAIT;
				end
				tndb_pkg::ST_ROOT_WAIT: begin
					if (it_done) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= tndb_pkg::ST_ROOT_GO;
						end else begin
							step_q  <= '0;
							axis_q  <= '0;
							state_q <= tndb_pkg::ST_BLEND;
						end
					end
				end
				tndb_pkg::ST_BLEND: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) begin
						state_q <= tndb_pkg::ST_DIV_GO;
					end
				end
				tndb_pkg::ST_DIV_GO: begin
					state_q <= tndb_pkg::ST_DIV_WAIT;
				end
				tndb_pkg::ST_DIV_WAIT: begin
					if (it_done) begin
						step_q <= '0;
						axis_q <= axis_q + 1'b1;
						state_q <= (axis_q == 2'd2) ? tndb_pkg::ST_FIN : tndb_pkg::ST_BLEND;
					end
				end
				tndb_pkg::ST_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q   <= tndb_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tndb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			tndb_pkg::ST_IDLE: begin
				qx_q     <= in_px;
				qy_q     <= in_py;
				qz_q     <= in_pz;
				res_q[0] <= in_vx;
				res_q[1] <= in_vy;
				res_q[2] <= in_vz;
			end
			tndb_pkg::ST_SCAN_MUL: begin
				if (step_q == 2'd1) begin
					acc_q <= prod_q[DW-1:0];
				end else if (step_q == 2'd2) begin
					acc_q <= sval;
				end else if (step_q == 2'd3) begin
					if (found_q == tndb_pkg::USED_NONE || sval < d1_q) begin
						d2_q <= d1_q;
						i2_q <= i1_q;
						d1_q <= sval;
						i1_q <= k_q[AW-1:0];
					end else if (found_q == tndb_pkg::USED_ONE || sval < d2_q) begin
						d2_q <= sval;
						i2_q <= k_q[AW-1:0];
					end
				end
			end
			tndb_pkg::ST_PICK_LD: begin
				if (!sel_q) begin
					dir1_q <= rd_d;
					dir2_q <= '{default: '0};
					r1_q   <= '0;
					r2_q   <= RW'(1);
				end else begin
					dir2_q <= rd_d;
				end
			end
			tndb_pkg::ST_ROOT_WAIT: begin
				if (it_done) begin
					if (!sel_q) begin
						r1_q <= it_res;
					end else if (r1_q == '0 && it_res == '0) begin
						r1_q <= RW'(1);
						r2_q <= RW'(1);
					end else begin
						r2_q <= it_res;
					end
				end
			end
			tndb_pkg::ST_BLEND: begin
				if (step_q == 2'd1) begin
					num_q <= NW'(prod_q);
				end else if (step_q == 2'd2) begin
					num_q <= num_q + NW'(prod_q);
				end
			end
			tndb_pkg::ST_DIV_GO: begin
				neg_q <= num_q[NW-1];
			end
			tndb_pkg::ST_DIV_WAIT: begin
				if (it_done) begin
					res_q[axis_q] <= q_sat;
				end
			end
			tndb_pkg::ST_FIN: begin
				if (!m_valid_q || m_axis_tready) begin
					m_data_q <= {6'b0, found_q,
						tndb_pkg::FIELD_W'(res_q[2]),
						tndb_pkg::FIELD_W'(res_q[1]),
						tndb_pkg::FIELD_W'(res_q[0])};
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== hw/rtl/tndb_chk.sv =====
// Port-level checks for the two-nearest direction blend, bound to the top level.
// Depends on tndb_pkg and two_nearest_direction_blend.
module tndb_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [tndb_pkg::M_DATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result changed.");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[73:72] != 2'b11)
		else $error("Guide count out of range.");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == tndb_pkg::ACT_QUERY
		|=> !s_axis_tready)
		else $error("Ready after query request.");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == tndb_pkg::ACT_LOAD
		|=> s_axis_tready)
		else $error("Load request stalled the block.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[79:74] == 6'b0)
		else $error("Result padding not zero.");

endmodule

bind two_nearest_direction_blend tndb_chk u_tndb_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

// ===== bench/two_nearest_direction_blend_tb.sv =====
// Self-checking testbench for the two-nearest direction blend.
// Loads guide entries, runs queries at several scan counts and handshake
// pressures, and checks each blended direction. Depends on tndb_pkg and the RTL.
`timescale 1ns / 100ps

module two_nearest_direction_blend_tb;

	localparam int NUM_SLOTS   = 64;
	localparam int DRAIN_WAIT  = 40;
	localparam longint CYCLE_LIMIT = 8000000;

	typedef logic signed [tndb_pkg::FIELD_W-1:0] coord_t;
	typedef logic signed [tndb_pkg::FIELD_W:0]   delta_t;

	typedef struct packed {
		coord_t                      dir_x;
		coord_t                      dir_y;
		coord_t                      dir_z;
		logic [tndb_pkg::USED_W-1:0] used;
	} blend_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tndb_pkg::CFG_W-1:0]      cfg_wdata = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [tndb_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
	logic                            s_axis_tuser = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [tndb_pkg::M_DATA_W-1:0]   m_axis_tdata;

	coord_t guide_pos_x [NUM_SLOTS];
	coord_t guide_pos_y [NUM_SLOTS];
	coord_t guide_pos_z [NUM_SLOTS];
	delta_t guide_vec_x [NUM_SLOTS];
	delta_t guide_vec_y [NUM_SLOTS];
	delta_t guide_vec_z [NUM_SLOTS];
	bit     slot_loaded [NUM_SLOTS];
	int unsigned scan_count = 0;

	blend_result_t pending_blends[$];
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  mismatches = 0;
	int  load_total = 0;
	int  query_total = 0;
	int  used_seen [3] = '{0, 0, 0};
	longint cycle_count = 0;

	two_nearest_direction_blend i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root = 0;
		longint unsigned probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic coord_t clamp_coord(input longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return coord_t'(v);
	endfunction

	// Weighted average with rounding of halves away from zero.
	function automatic longint weigh_axis(input longint a, input longint wa,
			input longint b, input longint wb);
		longint num;
		longint unsigned den, mag, quo;
		num = a * wa + b * wb;
		den = wa + wb;
		mag = (num < 0) ? longint'(-num) : num;
		quo = (mag + den / 2) / den;
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic longint unsigned dist_sq(input int slot, input coord_t px,
			input coord_t py, input coord_t pz);
		longint dx, dy, dz;
		dx = longint'(guide_pos_x[slot]) - longint'(px);
		dy = longint'(guide_pos_y[slot]) - longint'(py);
		dz = longint'(guide_pos_z[slot]) - longint'(pz);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	function automatic blend_result_t blend_nearest(input coord_t px, input coord_t py,
			input coord_t pz, input coord_t vx, input coord_t vy, input coord_t vz);
		blend_result_t r;
		int unsigned n;
		int found = 0;
		int near1 = 0, near2 = 0;
		longint unsigned d1 = 0, d2 = 0, s, r1, r2;
		n = (scan_count < NUM_SLOTS) ? scan_count : NUM_SLOTS;
		for (int k = 0; k < n; k++) begin
			s = dist_sq(k, px, py, pz);
			if (found == 0 || s < d1) begin
				d2 = d1;
				near2 = near1;
				d1 = s;
				near1 = k;
				if (found < 2)
					found++;
			end else if (found == 1 || s < d2) begin
				d2 = s;
				near2 = k;
				found = 2;
			end
		end
		if (found == 0) begin
			r.dir_x = vx;
			r.dir_y = vy;
			r.dir_z = vz;
			r.used = tndb_pkg::USED_NONE;
		end else if (found == 1) begin
			r.dir_x = clamp_coord(guide_vec_x[near1]);
			r.dir_y = clamp_coord(guide_vec_y[near1]);
			r.dir_z = clamp_coord(guide_vec_z[near1]);
			r.used = tndb_pkg::USED_ONE;
		end else begin
			r1 = int_sqrt(d1);
			r2 = int_sqrt(d2);
			if (r1 + r2 == 0) begin
				r1 = 1;
				r2 = 1;
			end
			r.dir_x = clamp_coord(weigh_axis(guide_vec_x[near1], r2, guide_vec_x[near2], r1));
			r.dir_y = clamp_coord(weigh_axis(guide_vec_y[near1], r2, guide_vec_y[near2], r1));
			r.dir_z = clamp_coord(weigh_axis(guide_vec_z[near1], r2, guide_vec_z[near2], r1));
			r.used = tndb_pkg::USED_TWO;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		blend_result_t want;
		coord_t got_x, got_y, got_z;
		logic [tndb_pkg::USED_W-1:0] got_used;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_x = m_axis_tdata[23:0];
			got_y = m_axis_tdata[47:24];
			got_z = m_axis_tdata[71:48];
			got_used = m_axis_tdata[73:72];
			if (pending_blends.size() == 0) begin
				$error("unexpected result: dir_x %0d dir_y %0d dir_z %0d guides_used %0d",
					got_x, got_y, got_z, got_used);
				mismatches++;
			end else begin
				want = pending_blends.pop_front();
				if (got_x !== want.dir_x) begin
					$error("dir_x expected %0d actual %0d", want.dir_x, got_x);
					mismatches++;
				end
				if (got_y !== want.dir_y) begin
					$error("dir_y expected %0d actual %0d", want.dir_y, got_y);
					mismatches++;
				end
				if (got_z !== want.dir_z) begin
					$error("dir_z expected %0d actual %0d", want.dir_z, got_z);
					mismatches++;
				end
				if (got_used !== want.used) begin
					$error("guides_used expected %0d actual %0d", want.used, got_used);
					mismatches++;
				end
				if (want.used <= tndb_pkg::USED_TWO)
					used_seen[want.used]++;
			end
		end
	end

	// Sends one request and leaves tvalid high; the caller lowers it with bus_idle.
	task automatic send_request(input logic act, input logic [tndb_pkg::IDX_W-1:0] slot,
			input coord_t px, input coord_t py, input coord_t pz,
			input coord_t vx, input coord_t vy, input coord_t vz);
		logic [tndb_pkg::S_DATA_W-1:0] data;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		data = '0;
		data[tndb_pkg::OFF_IDX +: tndb_pkg::IDX_W] = slot;
		data[tndb_pkg::OFF_POS_X +: tndb_pkg::FIELD_W] = px;
		data[tndb_pkg::OFF_POS_Y +: tndb_pkg::FIELD_W] = py;
		data[tndb_pkg::OFF_POS_Z +: tndb_pkg::FIELD_W] = pz;
		data[tndb_pkg::OFF_VEC_X +: tndb_pkg::FIELD_W] = vx;
		data[tndb_pkg::OFF_VEC_Y +: tndb_pkg::FIELD_W] = vy;
		data[tndb_pkg::OFF_VEC_Z +: tndb_pkg::FIELD_W] = vz;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= act;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (act == tndb_pkg::ACT_LOAD) begin
			guide_pos_x[slot] = px;
			guide_pos_y[slot] = py;
			guide_pos_z[slot] = pz;
			guide_vec_x[slot] = delta_t'(vx) - delta_t'(px);
			guide_vec_y[slot] = delta_t'(vy) - delta_t'(py);
			guide_vec_z[slot] = delta_t'(vz) - delta_t'(pz);
			slot_loaded[slot] = 1'b1;
			load_total++;
		end else begin
			pending_blends.push_back(blend_nearest(px, py, pz, vx, vy, vz));
			query_total++;
		end
	endtask

	task automatic load_guide(input int slot, input coord_t px, input coord_t py,
			input coord_t pz, input coord_t ex, input coord_t ey, input coord_t ez);
		send_request(tndb_pkg::ACT_LOAD, tndb_pkg::IDX_W'(slot), px, py, pz, ex, ey, ez);
	endtask

	task automatic query_point(input coord_t px, input coord_t py, input coord_t pz,
			input coord_t vx, input coord_t vy, input coord_t vz);
		send_request(tndb_pkg::ACT_QUERY, tndb_pkg::IDX_W'($urandom_range(63)),
			px, py, pz, vx, vy, vz);
	endtask

	task automatic bus_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_blends.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_scan_count(input int unsigned value);
		bus_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= tndb_pkg::CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		scan_count = value;
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom());
	endfunction

	function automatic bit prefix_loaded(input int unsigned count);
		int unsigned n = (count < NUM_SLOTS) ? count : NUM_SLOTS;
		for (int k = 0; k < n; k++)
			if (!slot_loaded[k])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic test_empty_table();
		query_point(24'sh7FFFFF, 24'sh800000, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		query_point(0, 0, 0, 24'sh800000, 24'sh800000, 24'sh800000);
		set_scan_count(0);
		query_point(rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
	endtask

	task automatic test_single_guide();
		// Start at one extreme and end at the other in x and y, so those axes of the lone direction saturate.
		load_guide(0, 24'sh7FFFFF, 24'sh800000, 0, 24'sh800000, 24'sh7FFFFF, 5);
		load_guide(63, 1, 2, 3, 4, 5, 6);
		set_scan_count(1);
		query_point(0, 0, 0, 7, 7, 7);
		query_point(24'sh800000, 24'sh7FFFFF, 24'sh800000, 0, 0, 0);
		load_guide(0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
			24'sh7FFFFF);
		query_point(5, 5, 5, 0, 0, 0);
	endtask

	task automatic test_two_guides();
		load_guide(1, 100, 0, 0, 103, 10, -7);
		load_guide(2, 100, 0, 0, 100, -3, 8);
		load_guide(3, -500, 40, 9, -450, 41, -1);
		set_scan_count(2);
		query_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0);
		query_point(100, 0, 0, 0, 0, 0);
		set_scan_count(4);
		// Slots one and two share a start: the tie goes to the earlier one,
		// and a query right on it averages the two directions.
		query_point(100, 0, 0, 0, 0, 0);
		query_point(-499, 40, 9, 0, 0, 0);
		query_point(24'sh800000, 24'sh800000, 24'sh800000, 0, 0, 0);
		query_point(0, 0, 0, 0, 0, 0);
	endtask

	task automatic load_random(input int slot);
		coord_t px, py, pz, ex, ey, ez;
		int donor;
		case ($urandom_range(9))
			0, 1: begin
				px = rand_coord(); py = rand_coord(); pz = rand_coord();
				ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
			end
			2, 3: begin
				donor = $urandom_range(NUM_SLOTS - 1);
				px = guide_pos_x[donor]; py = guide_pos_y[donor]; pz = guide_pos_z[donor];
				ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
			end
			default: begin
				px = coord_t'($signed($urandom_range(2000)) - 1000);
				py = coord_t'($signed($urandom_range(2000)) - 1000);
				pz = coord_t'($signed($urandom_range(60)) - 30);
				ex = coord_t'(px + $signed($urandom_range(400)) - 200);
				ey = coord_t'(py + $signed($urandom_range(400)) - 200);
				ez = coord_t'(pz + $signed($urandom_range(400)) - 200);
			end
		endcase
		load_guide(slot, px, py, pz, ex, ey, ez);
	endtask

	task automatic query_random();
		int slot;
		coord_t px, py, pz;
		slot = $urandom_range(NUM_SLOTS - 1);
		case ($urandom_range(9))
			0, 1, 2: begin
				px = rand_coord(); py = rand_coord(); pz = rand_coord();
			end
			3, 4: begin
				px = guide_pos_x[slot]; py = guide_pos_y[slot]; pz = guide_pos_z[slot];
			end
			default: begin
				px = coord_t'(guide_pos_x[slot] + $signed($urandom_range(200)) - 100);
				py = coord_t'(guide_pos_y[slot] + $signed($urandom_range(200)) - 100);
				pz = coord_t'(guide_pos_z[slot] + $signed($urandom_range(200)) - 100);
			end
		endcase
		query_point(px, py, pz, rand_coord(), rand_coord(), rand_coord());
	endtask

	function automatic int unsigned pick_scan_count();
		case ($urandom_range(9))
			0: return 0;
			1: return NUM_SLOTS;
			2: return 127;
			3: return $urandom_range(NUM_SLOTS);
			default: return $urandom_range(6, 1);
		endcase
	endfunction

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input int items);
		int unsigned count;
		set_scan_count(scan_count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < items; i++) begin
			if (i % 60 == 0) begin
				count = pick_scan_count();
				if (prefix_loaded(count))
					set_scan_count(count);
			end
			if ($urandom_range(1) == 0)
				load_random($urandom_range(NUM_SLOTS - 1));
			else
				query_random();
		end
		bus_idle();
	endtask

	task automatic test_fill_table();
		for (int k = 0; k < NUM_SLOTS; k++)
			load_random(k);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_single_guide();
		test_two_guides();
		test_fill_table();
		test_random_phase(0, 0, 500);
		test_random_phase(51, 0, 500);
		test_random_phase(0, 51, 500);
		test_random_phase(20, 20, 500);
		set_scan_count(127);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		query_random();
		bus_idle();
		$display("Covered %0d loads and %0d queries at scan counts up to 127.",
			load_total, query_total);
		$display("Results by guides used: none %0d, one %0d, two %0d.",
			used_seen[0], used_seen[1], used_seen[2]);
		if (mismatches == 0 && pending_blends.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== two_nearest_direction_blend.f =====
hw/rtl/tndb_pkg.sv
hw/rtl/tndb_ram.sv
hw/rtl/tndb_iter.sv
hw/rtl/two_nearest_direction_blend.sv
hw/rtl/tndb_chk.sv
bench/two_nearest_direction_blend_tb.sv
